[src/gpas_pkg.sv]
// Shared constants, table builders and the affine map for the power-map S-box.
package gpas_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned TABLE_DEPTH = 256;
   localparam int unsigned GROUP_ORDER = 255;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [BYTE_W-1:0] AFFINE_CONST = 8'h63;
   localparam logic [BYTE_W-1:0] EXP_RESET    = 8'd254;
   localparam logic [BYTE_W-1:0] POLY_LOW     = 8'h1B;

   // Register index is paddr[2]
   typedef enum logic [0:0] {
      REG_POWER_EXPONENT = 1'b0,
      REG_UNMAPPED       = 1'b1
   } reg_index_type;

   typedef logic [TABLE_DEPTH-1:0][BYTE_W-1:0] byte_table_type;

   function automatic logic [BYTE_W-1:0] gf_times_three(input logic [BYTE_W-1:0] a);
      logic [BYTE_W-1:0] dbl;
      dbl = {a[BYTE_W-2:0], 1'b0} ^ (a[BYTE_W-1] ? POLY_LOW : '0);
      return dbl ^ a;
   endfunction

   // antilog[k] = 3^k, last entry wraps to 1
   function automatic byte_table_type build_antilog_table();
      byte_table_type    t;
      logic [BYTE_W-1:0] v;
      t = '0;
      v = 8'h01;
      for (int k = 0; k < GROUP_ORDER; k++) begin
         t[k] = v;
         v    = gf_times_three(v);
      end
      t[TABLE_DEPTH-1] = 8'h01;
      return t;
   endfunction

   // log[3^k] = k, entry for zero holds zero
   function automatic byte_table_type build_log_table();
      byte_table_type    t;
      logic [BYTE_W-1:0] v;
      t = '0;
      v = 8'h01;
      for (int k = 0; k < GROUP_ORDER; k++) begin
         t[v] = BYTE_W'(k);
         v    = gf_times_three(v);
      end
      return t;
   endfunction

   function automatic logic [BYTE_W-1:0] aes_affine(input logic [BYTE_W-1:0] y);
      return y
         ^ {y[6:0], y[7]}
         ^ {y[5:0], y[7:6]}
         ^ {y[4:0], y[7:5]}
         ^ {y[3:0], y[7:4]}
         ^ AFFINE_CONST;
   endfunction

endpackage

[src/gpas_csr.sv]
// Configuration register block holding the power exponent.
module gpas_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [gpas_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [gpas_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [gpas_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output logic [gpas_pkg::BYTE_W-1:0]        exponent
);
   import gpas_pkg::*;

   logic [BYTE_W-1:0] exponent_ff;
   logic [BYTE_W-1:0] exponent_in;
   reg_index_type     reg_index;
   logic              write_beat;

   assign reg_index  = reg_index_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;
   assign write_beat = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      exponent_in = exponent_ff;
      if (write_beat && reg_index == REG_POWER_EXPONENT) begin
         exponent_in = csr_pwdata[BYTE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff <= EXP_RESET;
      end else begin
         exponent_ff <= exponent_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_POWER_EXPONENT: csr_prdata = CSR_DATA_W'(exponent_ff);
         REG_UNMAPPED:       csr_prdata = '0;
         default:            csr_prdata = '0;
      endcase
   end

   assign exponent = exponent_ff;

   a_reset_value: assert property (@(posedge clock) reset |=> exponent_ff == EXP_RESET)
      else $error("exponent not restored by reset");

   a_write_lands: assert property (@(posedge clock) disable iff (reset)
      (write_beat && reg_index == REG_POWER_EXPONENT)
      |=> exponent_ff == $past(csr_pwdata[BYTE_W-1:0]))
      else $error("exponent write lost");

endmodule

[src/gpas_power_unit.sv]
// Power map x^e in GF(2^8) via log/antilog tables, followed by the AES affine map.
module gpas_power_unit (
   input  logic [gpas_pkg::BYTE_W-1:0] in_byte,
   input  logic [gpas_pkg::BYTE_W-1:0] exponent,
   output logic [gpas_pkg::BYTE_W-1:0] sbox_out
);
   import gpas_pkg::*;

   localparam byte_table_type LOG_TABLE     = build_log_table();
   localparam byte_table_type ANTILOG_TABLE = build_antilog_table();

   logic [BYTE_W-1:0]   log_x;
   logic [2*BYTE_W-1:0] product;
   logic [BYTE_W:0]     fold_sum;
   logic [BYTE_W-1:0]   log_y;
   logic [BYTE_W-1:0]   power;

   assign log_x   = LOG_TABLE[in_byte];
   assign product = log_x * exponent;

   // mod 255: 256 == 1, so fold high byte onto low byte twice.
   // A residue of 255 indexes the wrap entry, which equals entry zero.
   assign fold_sum = {1'b0, product[2*BYTE_W-1:BYTE_W]} + {1'b0, product[BYTE_W-1:0]};
   assign log_y    = fold_sum[BYTE_W-1:0] + BYTE_W'(fold_sum[BYTE_W]);

   assign power    = (in_byte == '0) ? '0 : ANTILOG_TABLE[log_y];
   assign sbox_out = aes_affine(power);

endmodule

[src/gf256_power_affine_sbox.sv]
// Top level of the configurable power-map byte substitution box.
// Each byte x on req_ is answered on rsp_ by affine(x^e) in GF(2^8) (poly 0x11B), zero
// giving affine(0) = 0x63; e is the csr register at address 0 (reset 254 = AES S-box).
// One beat per cycle is taken and given while rsp_tready is high; each beat goes from input
// register to result register, through the table lookups, 8x8 multiply and mod-255 fold.
// A stalled result holds in the result register while the input register still takes
// one more beat. Write the exponent only while no beats are in flight.
module gf256_power_affine_sbox (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [gpas_pkg::BYTE_W-1:0]      req_tdata,   // [7:0] in_byte
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [gpas_pkg::BYTE_W-1:0]      rsp_tdata,   // [7:0] sbox_out
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [gpas_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [gpas_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [gpas_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import gpas_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic [BYTE_W-1:0] exponent;
   logic [BYTE_W-1:0] sbox_out;
   logic              advance;
   logic              req_beat;

   gpas_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .exponent    (exponent)
   );

   gpas_power_unit u_power (
      .in_byte  (in_byte_ff),
      .exponent (exponent),
      .sbox_out (sbox_out)
   );

   // result register free, or being drained this cycle
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
         out_byte_in  = sbox_out;
      end
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff  <= in_byte_in;
      out_byte_ff <= out_byte_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff))
      else $error("input stalled with a free stage");

   a_stage_moves_on: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance) |=> out_valid_ff)
      else $error("beat dropped between stages");

   a_zero_maps_to_const: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance && in_byte_ff == '0) |=> rsp_tdata == AFFINE_CONST)
      else $error("zero byte not mapped to affine constant");

endmodule

[test/tb_gf256_power_affine_sbox.sv]
`timescale 1ns / 100ps
// Self-checking bench for the power-map S-box: stream traffic, exponent writes and backpressure.
module tb_gf256_power_affine_sbox;
   import gpas_pkg::*;

   localparam int unsigned CYCLE_LIMIT       = 400000;
   localparam int unsigned DRAIN_CYCLES      = 8;
   localparam int unsigned SETTLE_CYCLES     = 4;
   localparam int unsigned ITEMS_PER_MODE    = 600;
   localparam int unsigned ITEMS_PER_SETTING = 75;
   localparam int unsigned STALL_CYCLES      = 48;
   localparam int unsigned BURST_ITEMS       = 24;

   typedef logic [BYTE_W-1:0] byte_type;

   typedef struct packed {
      byte_type in_byte;
      byte_type exponent;
      byte_type sbox_out;
   } sbox_pending_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   byte_type              req_tdata   = '0;   // [7:0] in_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   byte_type              rsp_tdata;          // [7:0] sbox_out
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   byte_type         pow3_tab [TABLE_DEPTH];
   byte_type         dlog_tab [TABLE_DEPTH];
   byte_type         exponent_shadow = EXP_RESET;
   sbox_pending_type pending_q[$];

   int     send_idle_pct = 0;
   int     recv_idle_pct = 0;
   int     hold_left     = 0;
   int     error_count   = 0;
   int     bytes_sent    = 0;
   int     bytes_checked = 0;
   int     exp_writes    = 0;
   longint cycle_count   = 0;

   gf256_power_affine_sbox uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- prediction

   function automatic byte_type gf_mul3(input byte_type a);
      byte_type dbl;
      dbl = a[7] ? (byte_type'(a << 1) ^ POLY_LOW) : byte_type'(a << 1);
      return dbl ^ a;
   endfunction

   function automatic byte_type rotl(input byte_type y, input int k);
      return byte_type'(y << k) | byte_type'(y >> (BYTE_W - k));
   endfunction

   function automatic byte_type predict_sbox(input byte_type x, input byte_type e);
      byte_type    y;
      int unsigned idx;
      y = '0;
      if (x != 0) begin
         idx = (int'(dlog_tab[x]) * int'(e)) % GROUP_ORDER;
         y   = pow3_tab[idx];
      end
      return y ^ rotl(y, 1) ^ rotl(y, 2) ^ rotl(y, 3) ^ rotl(y, 4) ^ AFFINE_CONST;
   endfunction

   // ---------------------------------------------------------------- random picks

   function automatic byte_type pick_byte();
      case ($urandom_range(0, 15))
         0: return 8'h00;
         1: return 8'hFF;
         default: return byte_type'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic byte_type pick_exponent();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd254;
         3: return 8'd255;
         default: return byte_type'($urandom_range(0, 255));
      endcase
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   always @(posedge clock) begin : check_results
      sbox_pending_type head;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_q.size() == 0) begin
            report_mismatch($sformatf("result beat %02h with nothing outstanding", rsp_tdata));
         end else begin
            head = pending_q.pop_front();
            bytes_checked++;
            if (rsp_tdata !== head.sbox_out)
               report_mismatch($sformatf("x=%02h e=%0d: sbox_out %02h, want %02h",
                                         head.in_byte, head.exponent, rsp_tdata, head.sbox_out));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_q.size());
         $display("tb_gf256_power_affine_sbox: done, errors");
         $finish;
      end
   end

   // result side: random idling, or a counted hold-off when one is requested
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------- drivers
   // all driver tasks are entered and left just after a falling edge

   task automatic send_byte(input byte_type b);
      sbox_pending_type p;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      p.in_byte  = b;
      p.exponent = exponent_shadow;
      p.sbox_out = predict_sbox(b, exponent_shadow);
      pending_q.push_back(p);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic wait_quiet(input int unsigned tail);
      req_tvalid = 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      if (idx == REG_POWER_EXPONENT) begin
         exponent_shadow = value[BYTE_W-1:0];
         exp_writes++;
      end
   endtask

   task automatic csr_check_exponent();
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b0;
      csr_penable = 1'b0;
      csr_paddr   = CSR_ADDR_W'({REG_POWER_EXPONENT, 2'b00});
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[BYTE_W-1:0] !== exponent_shadow)
         report_mismatch($sformatf("exponent reads %0d, want %0d",
                                   csr_prdata[BYTE_W-1:0], exponent_shadow));
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic set_exponent(input byte_type e);
      wait_quiet(SETTLE_CYCLES);
      csr_write(REG_POWER_EXPONENT, CSR_DATA_W'(e));
      csr_check_exponent();
   endtask

   // ---------------------------------------------------------------- tests

   // reset exponent is the plain AES S-box
   task automatic test_reset_state();
      csr_check_exponent();
      send_byte(8'h00);
      send_byte(8'h01);
      send_byte(8'h02);
      send_byte(8'h03);
      send_byte(8'h80);
      send_byte(8'hFF);
      send_byte(8'h53);
   endtask

   task automatic test_unmapped_write();
      wait_quiet(SETTLE_CYCLES);
      csr_write(REG_UNMAPPED, '1);
      csr_check_exponent();
      send_byte(8'h53);
   endtask

   // exponents that collapse every nonzero byte to one, plus the identity power
   task automatic test_degenerate_exponents();
      byte_type exps[3];
      exps = '{8'd0, 8'd255, 8'd1};
      foreach (exps[i]) begin
         set_exponent(exps[i]);
         send_byte(8'h00);
         send_byte(8'h80 | byte_type'($urandom_range(1, 127)));
         send_byte(8'hFF);
      end
   endtask

   task automatic test_random_traffic(input int sidle, input int ridle);
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      for (int s = 0; s < ITEMS_PER_MODE / ITEMS_PER_SETTING; s++) begin
         set_exponent(pick_exponent());
         if ($urandom_range(0, 3) == 0) begin
            csr_write(REG_UNMAPPED, CSR_DATA_W'($urandom()));
            csr_check_exponent();
         end
         for (int n = 0; n < ITEMS_PER_SETTING; n++)
            send_byte(pick_byte());
      end
   endtask

   // long output stall with input still offered, then a full pause until drained
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_exponent(pick_exponent());
      @(posedge clock);
      hold_left = STALL_CYCLES;
      @(negedge clock);
      for (int n = 0; n < BURST_ITEMS; n++)
         send_byte(pick_byte());
      wait_quiet(0);
      for (int n = 0; n < BURST_ITEMS; n++)
         send_byte(pick_byte());
   endtask

   initial begin : main
      byte_type v;
      v = 8'h01;
      dlog_tab[0] = '0;
      for (int k = 0; k < GROUP_ORDER; k++) begin
         pow3_tab[k] = v;
         dlog_tab[v] = byte_type'(k);
         v           = gf_mul3(v);
      end
      pow3_tab[TABLE_DEPTH-1] = 8'h01;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_unmapped_write();
      test_degenerate_exponents();
      test_random_traffic(28, 62);
      test_random_traffic(62, 28);
      test_random_traffic(0, 0);
      test_backpressure();

      wait_quiet(DRAIN_CYCLES);
      $display("covered %0d bytes in, %0d results checked, %0d exponent settings",
               bytes_sent, bytes_checked, exp_writes);
      $display("with both sides idling, an unmapped write and a long output stall");
      if (error_count == 0) begin
         $display("tb_gf256_power_affine_sbox: done, clean");
      end else begin
         $display("tb_gf256_power_affine_sbox: done, errors");
      end
      $finish;
   end

endmodule
